// ===== rtl/core/knn_jaccard_edge_weights_defines.svh =====
// Assertion helpers used by the checker of this block.
`ifndef KNN_JACCARD_EDGE_WEIGHTS_DEFINES_SVH
`define KNN_JACCARD_EDGE_WEIGHTS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KJE_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kje check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define KJE_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kje check failed");

`endif

// ===== rtl/core/kje_pkg.sv =====
`timescale 1ns / 1ps
package kje_pkg;

  localparam int ROW_W      = 10;
  localparam int COL_W      = 4;
  localparam int NIDX_W     = 11;
  localparam int ENTRY_W    = 11;
  localparam int WEIGHT_W   = 17;
  localparam int FRAC_W     = 16;
  localparam int CFG_N_W    = 11;
  localparam int CFG_K_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELF = 2'd2;

  localparam logic [CFG_N_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [CFG_K_W-1:0] COLS_RESET = 5'd16;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    KIND_ACK    = 1'b0,
    KIND_WEIGHT = 1'b1
  } kind_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic [NIDX_W-1:0]   neighbour_index;
    logic                is_padding;
  } command_t;

  typedef struct packed {
    kind_t               kind;
    logic                error;
    logic [COL_W-1:0]    result_column;
    logic [WEIGHT_W-1:0] weight;
    logic                weight_valid;
    logic                last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_A,
    ST_DRAIN_A,
    ST_COL,
    ST_SCAN_B,
    ST_DRAIN_B,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_EMIT,
    ST_BLANK
  } state_t;

  typedef struct packed {
    logic latch;
    logic do_write;
    logic emit_ack;
    logic col_clear;
    logic scan_a_init;
    logic scan_b_init;
    logic rd_issue;
    logic div_start;
    logic div_step;
    logic emit;
    logic col_next;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic row_bad;
    logic cnt_last;
    logic col_last;
    logic col_skip;
    logic div_last;
  } ctl_stat_t;

endpackage

// ===== rtl/core/kje_ctrl.sv =====
`timescale 1ns / 1ps
module kje_ctrl import kje_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd,
  output logic      busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.col_clear = 1'b1;
        if (stat.is_write) begin
          cmd.do_write = 1'b1;
          cmd.emit_ack = 1'b1;
          state_next   = ST_IDLE;
        end else if (stat.row_bad) begin
          state_next = ST_BLANK;
        end else begin
          cmd.scan_a_init = 1'b1;
          state_next      = ST_SCAN_A;
        end
      end
      ST_SCAN_A: begin
        cmd.rd_issue = 1'b1;
        if (stat.cnt_last) state_next = ST_DRAIN_A;
      end
      ST_DRAIN_A: state_next = ST_COL;
      ST_COL: begin
        if (stat.col_skip) begin
          cmd.emit     = 1'b1;
          cmd.col_next = 1'b1;
          state_next   = stat.col_last ? ST_IDLE : ST_COL;
        end else begin
          cmd.scan_b_init = 1'b1;
          state_next      = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        cmd.rd_issue = 1'b1;
        if (stat.cnt_last) state_next = ST_DRAIN_B;
      end
      ST_DRAIN_B: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.col_next = 1'b1;
        state_next   = stat.col_last ? ST_IDLE : ST_COL;
      end
      ST_BLANK: begin
        cmd.emit     = 1'b1;
        cmd.col_next = 1'b1;
        state_next   = stat.col_last ? ST_IDLE : ST_BLANK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/kje_dpath.sv =====
`timescale 1ns / 1ps
module kje_dpath import kje_pkg::*; #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  command_t              command,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctl_cmd_t              cmd,
  output ctl_stat_t             stat,
  output result_t               result,
  output logic                  done
);

  localparam int SET_CAP = MAX_COLUMNS + 1;
  localparam int LW      = $clog2(SET_CAP + 1);
  localparam int SIW     = $clog2(SET_CAP);
  localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
  localparam int AW      = $clog2(DEPTH);
  localparam int CIW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int DNW     = LW + 1;
  localparam int DVW     = LW + FRAC_W;
  localparam int DCW     = $clog2(DVW);
  localparam int NMAX    = (MAX_ROWS > 2047) ? 2047 : MAX_ROWS;
  localparam int KMAX    = (MAX_COLUMNS > 31) ? 31 : MAX_COLUMNS;

  logic [CFG_N_W-1:0] rows_cfg;
  logic [CFG_K_W-1:0] cols_cfg;
  logic               self_cfg;
  logic [CFG_N_W-1:0] n_eff;
  logic [CFG_K_W-1:0] k_eff, k_last;

  command_t q;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] rrow, v, j, cur, own_a;

  logic               scan_b, rd_pend;
  logic [CIW-1:0]     cnt, t, rd_col;

  logic [ENTRY_W-1:0] colv  [MAX_COLUMNS];
  logic [ENTRY_W-1:0] a_set [SET_CAP];
  logic [ENTRY_W-1:0] b_set [SET_CAP];
  logic [LW-1:0]      a_len, b_len, u;
  logic               hit_a_v, hit_b_v, hit_a_cur;

  logic [DNW-1:0]     den, rem;
  logic [DNW:0]       trial;
  logic [DVW-1:0]     dvd;
  logic [DCW-1:0]     dcnt;
  logic               wr_err, wvalid;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLS_RESET;
      self_cfg <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_cfg <= cfg_data;
        REG_COLS: cols_cfg <= cfg_data[CFG_K_W-1:0];
        REG_SELF: self_cfg <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (rows_cfg == '0)                n_eff = CFG_N_W'(1);
    else if (int'(rows_cfg) > NMAX)    n_eff = CFG_N_W'(NMAX);
    else                               n_eff = rows_cfg;
    if (cols_cfg == '0)                k_eff = CFG_K_W'(1);
    else if (int'(cols_cfg) > KMAX)    k_eff = CFG_K_W'(KMAX);
    else                               k_eff = cols_cfg;
    k_last = k_eff - CFG_K_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) q <= command;
  end

  assign stat.is_write = (q.opcode == OP_WRITE);
  assign stat.row_bad  = ({1'b0, q.row} >= n_eff);
  assign wr_err = stat.row_bad || ({1'b0, q.column} >= k_eff) ||
                  (!q.is_padding && ((q.neighbour_index == '0) ||
                                     (q.neighbour_index > n_eff)));

  // index store
  assign waddr = AW'(AW'(q.row) * AW'(MAX_COLUMNS)) + AW'(q.column);
  assign rrow  = scan_b ? (j - ENTRY_W'(1)) : ENTRY_W'(q.row);
  assign raddr = AW'(AW'(rrow) * AW'(MAX_COLUMNS)) + AW'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.do_write && !wr_err)
      mem[waddr] <= q.is_padding ? '0 : q.neighbour_index;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rdata <= mem[raddr];
  end

  assign v     = (rdata > n_eff) ? '0 : rdata;
  assign cur   = colv[t];
  assign own_a = ENTRY_W'(q.row) + ENTRY_W'(1);

  always_comb begin
    hit_a_v   = 1'b0;
    hit_b_v   = 1'b0;
    hit_a_cur = 1'b0;
    for (int i = 0; i < SET_CAP; i++) begin
      if (LW'(i) < a_len && a_set[i] == v)   hit_a_v   = 1'b1;
      if (LW'(i) < b_len && b_set[i] == v)   hit_b_v   = 1'b1;
      if (LW'(i) < a_len && a_set[i] == cur) hit_a_cur = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pend <= 1'b0;
    else     rd_pend <= cmd.rd_issue;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      cnt    <= cnt + CIW'(1);
      rd_col <= cnt;
    end
    if (cmd.col_clear) t <= '0;
    else if (cmd.col_next) t <= t + CIW'(1);
    if (cmd.scan_a_init) begin
      scan_b   <= 1'b0;
      cnt      <= '0;
      a_set[0] <= own_a;
      a_len    <= self_cfg ? LW'(1) : '0;
    end else if (cmd.scan_b_init) begin
      scan_b   <= 1'b1;
      cnt      <= '0;
      j        <= cur;
      b_set[0] <= cur;
      b_len    <= self_cfg ? LW'(1) : '0;
      u        <= (self_cfg && hit_a_cur) ? LW'(1) : '0;
    end else if (rd_pend) begin
      if (!scan_b) begin
        colv[rd_col] <= v;
        if (v != '0 && v != own_a && !hit_a_v && a_len < LW'(SET_CAP)) begin
          a_set[a_len[SIW-1:0]] <= v;
          a_len <= a_len + LW'(1);
        end
      end else if (v != '0 && v != j && !hit_b_v && b_len < LW'(SET_CAP)) begin
        b_set[b_len[SIW-1:0]] <= v;
        b_len <= b_len + LW'(1);
        if (hit_a_v) u <= u + LW'(1);
      end
    end
  end

  assign stat.cnt_last = (CFG_K_W'(cnt) == k_last);
  assign stat.col_last = (CFG_K_W'(t) == k_last);
  assign stat.col_skip = (cur == '0) || (a_len == '0);

  // restoring divider, one quotient bit a cycle
  assign trial = {rem, dvd[DVW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      den  <= DNW'(a_len) + DNW'(b_len) - DNW'(u);
      rem  <= '0;
      dvd  <= {u, {FRAC_W{1'b0}}};
      dcnt <= DCW'(DVW - 1);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - DCW'(1);
      if (trial >= {1'b0, den}) begin
        rem <= DNW'(trial - {1'b0, den});
        dvd <= {dvd[DVW-2:0], 1'b1};
      end else begin
        rem <= trial[DNW-1:0];
        dvd <= {dvd[DVW-2:0], 1'b0};
      end
    end
  end

  assign stat.div_last = (dcnt == '0);

  // result beat
  assign wvalid = !stat.row_bad && !stat.col_skip && (b_len != '0);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.emit_ack || cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      result.kind          <= KIND_ACK;
      result.error         <= wr_err;
      result.result_column <= '0;
      result.weight        <= '0;
      result.weight_valid  <= 1'b0;
      result.last          <= 1'b1;
    end else if (cmd.emit) begin
      result.kind          <= KIND_WEIGHT;
      result.error         <= 1'b0;
      result.result_column <= COL_W'(t);
      result.weight        <= wvalid ? dvd[WEIGHT_W-1:0] : '0;
      result.weight_valid  <= wvalid;
      result.last          <= stat.col_last;
    end
  end

endmodule

// ===== rtl/core/knn_jaccard_edge_weights.sv =====
`timescale 1ns / 1ps
// Channel   Handshake           Beat
// command   start / busy        command_t, taken on start && !busy
// result    done (one cycle)    result_t, no back-pressure
// config    cfg_valid/ready     cfg_index, cfg_data; cfg_ready always high
//
// A write is latched, decoded and then acknowledged by a registered beat.
// A query first scans its own row of the index store; each column then scans
// one row through the single read port and runs a 21-step restoring divide.
// A padding column, or a row whose own set is empty, skips both.
// rst is synchronous; the index store is not cleared and holds garbage until
// written. Results cannot be stalled; busy falls in the cycle of the last beat.
module knn_jaccard_edge_weights import kje_pkg::*; #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  command_t              command,
  output result_t               result,
  output logic                  done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  kje_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  kje_dpath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

endmodule

// ===== rtl/core/kje_checker.sv =====
`timescale 1ns / 1ps
`include "knn_jaccard_edge_weights_defines.svh"
module kje_checker import kje_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input result_t result,
  input logic    done
);

  `KJE_HOLDS(ack_is_last, done && result.kind == KIND_ACK, result.last)
  `KJE_HOLDS(ack_no_weight, done && result.kind == KIND_ACK, !result.weight_valid && result.weight == '0)
  `KJE_HOLDS(invalid_zero, done && !result.weight_valid, result.weight == '0)
  `KJE_HOLDS(weight_range, done && result.weight_valid, result.weight <= 17'd65536)
  `KJE_NEXT(start_busy, start && !busy, busy)

endmodule

bind knn_jaccard_edge_weights kje_checker u_kje_checker (.*);

// ===== tb/knn_jaccard_edge_weights_checker.sv =====
`timescale 1ns / 1ps
module knn_jaccard_edge_weights_checker import kje_pkg::*; #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_COLUMNS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  command_t              command,
  input  result_t               result,
  input  logic                  done,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int SET_MAX = MAX_COLUMNS + 1;

  logic [ENTRY_W-1:0] cells [MAX_ROWS*MAX_COLUMNS];
  logic [CFG_N_W-1:0] rows_reg;
  logic [CFG_K_W-1:0] cols_reg;
  logic               self_reg;
  result_t            weights_due[$];

  assign outstanding = weights_due.size();

  function automatic int rows_eff();
    if (rows_reg < 1) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic int cols_eff();
    if (cols_reg < 1) return 1;
    if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(cols_reg);
  endfunction

  function automatic int cell_at(int r, int c, int n);
    int v;
    v = int'(cells[r*MAX_COLUMNS + c]);
    return (v > n) ? 0 : v;
  endfunction

  task automatic gather(input int r, input int n, input int k,
                        output int s[SET_MAX], output int len);
    int v;
    bit seen;
    len = 0;
    for (int a = 0; a < SET_MAX; a++) s[a] = -1;
    if (self_reg) begin
      s[0] = r;
      len = 1;
    end
    for (int t = 0; t < k; t++) begin
      v = cell_at(r, t, n);
      if (v != 0 && v - 1 != r) begin
        seen = 0;
        for (int a = 0; a < len; a++) if (s[a] == v - 1) seen = 1;
        if (!seen && len < SET_MAX) begin
          s[len] = v - 1;
          len++;
        end
      end
    end
  endtask

  task automatic predict(input command_t c);
    int n, k, v, la, lb, common, denom;
    int sa[SET_MAX];
    int sb[SET_MAX];
    result_t e;
    n = rows_eff();
    k = cols_eff();
    e = '0;
    if (c.opcode == OP_WRITE) begin
      e.kind = KIND_ACK;
      e.last = 1'b1;
      if (c.row >= n || c.column >= k) e.error = 1'b1;
      else if (!c.is_padding && (c.neighbour_index < 1 || c.neighbour_index > n))
        e.error = 1'b1;
      if (!e.error)
        cells[int'(c.row)*MAX_COLUMNS + int'(c.column)] =
          c.is_padding ? '0 : c.neighbour_index;
      weights_due = {weights_due, e};
    end else begin
      la = 0;
      if (c.row < n) gather(int'(c.row), n, k, sa, la);
      for (int t = 0; t < k; t++) begin
        e = '0;
        e.kind = KIND_WEIGHT;
        e.result_column = t[COL_W-1:0];
        e.last = (t == k - 1);
        if (c.row < n) begin
          v = cell_at(int'(c.row), t, n);
          if (v != 0 && la != 0) begin
            gather(v - 1, n, k, sb, lb);
            if (lb != 0) begin
              common = 0;
              for (int a = 0; a < la; a++)
                for (int b = 0; b < lb; b++) if (sa[a] == sb[b]) common++;
              denom = la + lb - common;
              e.weight = WEIGHT_W'((longint'(common) << FRAC_W) / denom);
              e.weight_valid = 1'b1;
            end
          end
        end
        weights_due = {weights_due, e};
      end
    end
  endtask

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare(input result_t got);
    result_t want;
    if (weights_due.size() == 0) begin
      report($sformatf("unexpected beat %p", got));
      return;
    end
    want = weights_due.pop_front();
    if (got.kind != want.kind)
      report($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.error != want.error)
      report($sformatf("error %0d, want %0d", got.error, want.error));
    if (got.result_column != want.result_column)
      report($sformatf("column %0d, want %0d", got.result_column, want.result_column));
    if (got.weight != want.weight)
      report($sformatf("col %0d weight %0d, want %0d", want.result_column,
                       got.weight, want.weight));
    if (got.weight_valid != want.weight_valid)
      report($sformatf("col %0d valid %0d, want %0d", want.result_column,
                       got.weight_valid, want.weight_valid));
    if (got.last != want.last)
      report($sformatf("last %0d, want %0d", got.last, want.last));
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      rows_reg <= ROWS_RESET;
      cols_reg <= COLS_RESET;
      self_reg <= 1'b1;
      weights_due.delete();
    end else begin
      if (done) compare(result);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: rows_reg <= cfg_data[CFG_N_W-1:0];
          REG_COLS: cols_reg <= cfg_data[CFG_K_W-1:0];
          REG_SELF: self_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) predict(command);
    end
  end

endmodule

// ===== tb/knn_jaccard_edge_weights_tb.sv =====
`timescale 1ns / 1ps
module knn_jaccard_edge_weights_tb import kje_pkg::*;;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLUMNS = 16;
  localparam int CYCLE_LIMIT = 1500000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  command_t              command = '0;
  result_t               result;
  logic                  done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;
  int                    cycles = 0;

  // shadow of the table, used only to steer stimulus away from unwritten cells
  int  shadow  [MAX_ROWS*MAX_COLUMNS];
  bit  written [MAX_ROWS*MAX_COLUMNS];
  int  n_now = MAX_ROWS;
  int  k_now = MAX_COLUMNS;
  int  idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  knn_jaccard_edge_weights #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) DUT (
    .clk, .rst, .start, .busy, .command, .result, .done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  knn_jaccard_edge_weights_checker #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_checker (
    .clk, .rst, .start, .busy, .command, .result, .done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches, .outstanding
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL knn_jaccard_edge_weights");
      $finish;
    end
  end

  task automatic send(input command_t c);
    bit ok;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    if (c.opcode == OP_WRITE) begin
      ok = c.row < n_now && c.column < k_now &&
           (c.is_padding || (c.neighbour_index >= 1 && c.neighbour_index <= n_now));
      if (ok) begin
        shadow[int'(c.row)*MAX_COLUMNS + int'(c.column)] =
          c.is_padding ? 0 : int'(c.neighbour_index);
        written[int'(c.row)*MAX_COLUMNS + int'(c.column)] = 1;
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int rows, input int cols, input int self_on);
    settle();
    set_reg(REG_ROWS, rows);
    set_reg(REG_COLS, cols);
    set_reg(REG_SELF, self_on);
    cfg_valid <= 1'b0;
    n_now = rows < 1 ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows);
    k_now = (cols % 32) < 1 ? 1 : ((cols % 32) > MAX_COLUMNS ? MAX_COLUMNS : cols % 32);
  endtask

  // first cell that a query of row r would read before it is written
  function automatic bit find_gap(input int r, output int gr, output int gc);
    int v;
    for (int c = 0; c < k_now; c++)
      if (!written[r*MAX_COLUMNS + c]) begin
        gr = r; gc = c;
        return 1;
      end
    for (int c = 0; c < k_now; c++) begin
      v = shadow[r*MAX_COLUMNS + c];
      if (v >= 1 && v <= n_now)
        for (int d = 0; d < k_now; d++)
          if (!written[(v-1)*MAX_COLUMNS + d]) begin
            gr = v - 1; gc = d;
            return 1;
          end
    end
    return 0;
  endfunction

  function automatic int pool_row(input int i);
    case (i)
      0: return 0;
      1: return n_now > 1 ? 1 : 0;
      default: return n_now - 1;
    endcase
  endfunction

  function automatic command_t make_write(int r, int c, int idx, bit pad);
    command_t w;
    w.opcode          = OP_WRITE;
    w.row             = ROW_W'(r);
    w.column          = COL_W'(c);
    w.neighbour_index = NIDX_W'(idx);
    w.is_padding      = pad;
    return w;
  endfunction

  task automatic run_phase(input int min_items);
    int sent, queries, r, gr, gc, pick, idx;
    command_t c;
    sent = 0;
    queries = 0;
    while (sent < min_items || queries < 4) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        c = command_t'($urandom);
        c.opcode = OP_WRITE;
        c.neighbour_index = $urandom_range(1) ? NIDX_W'($urandom) : NIDX_W'(n_now + 1);
      end else if (pick < 20 && n_now < MAX_ROWS) begin
        c = command_t'($urandom);
        c.opcode = OP_QUERY;
        c.row = ROW_W'($urandom_range(MAX_ROWS - 1, n_now));
        queries++;
      end else begin
        r = pool_row($urandom_range(2));
        if (find_gap(r, gr, gc)) begin
          pick = $urandom_range(99);
          if (pick < 65) idx = pool_row($urandom_range(2)) + 1;
          else if (pick < 80) idx = gr + 1;
          else idx = $urandom_range(n_now, 1);
          c = make_write(gr, gc, idx, $urandom_range(99) < 12);
        end else begin
          c = command_t'($urandom);
          c.opcode = OP_QUERY;
          c.row = ROW_W'(r);
          queries++;
        end
      end
      send(c);
      sent++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(1024, 16, 1);
    send(make_write(1023, 15, 1024, 0));
    send(make_write(0, 0, 0, 0));
    send(make_write(0, 0, 1025, 0));
    send(make_write(0, 0, 2047, 1));
    send(make_write(1023, 15, 0, 1));
    send(make_write(1023, 15, 1023, 0));
    run_phase(20);

    configure(8, 4, 0);     idle_pct = 51; run_phase(22);
    configure(1, 1, 1);     idle_pct = 15; run_phase(18);
    configure(0, 31, 0);    idle_pct = 0;  run_phase(18);
    configure(2047, 0, 1);  idle_pct = 51; run_phase(22);
    configure(5, 16, 1);    idle_pct = 15; run_phase(22);
    configure(300, 7, 0);   idle_pct = 0;  run_phase(22);
    configure(3, 2, 1);     idle_pct = 51; run_phase(22);

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS knn_jaccard_edge_weights");
    end else begin
      $display("FAIL knn_jaccard_edge_weights");
    end
    $finish;
  end

endmodule
